>>> sv/gbi_pkg.sv
// Shared constants and types for the grid bilinear interpolator.
`default_nettype none
package gbi_pkg;

  localparam int MAX_COLUMNS = 64;
  localparam int MAX_ROWS    = 64;
  localparam int VALUE_BITS  = 24;

  localparam int FIELD_W     = 24;
  localparam int COORD_W     = 32;
  localparam int CFG_INDEX_W = 4;
  localparam int CFG_DATA_W  = 32;
  localparam int LOAD_IDX_W  = 12;
  localparam int COUNT_W     = 7;
  localparam int WT_W        = 17;

  // One in Q1.16 weight format and one half in Q.32 grid units.
  localparam logic [WT_W-1:0] WT_ONE    = 17'h1_0000;
  localparam logic [63:0]     HALF_Q32  = 64'h0000_0000_8000_0000;

  localparam logic [31:0] INV_SPACING_RESET = 32'h0100_0000;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_QUERY = 1'b1
  } op_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_X_ORIGIN      = 4'd0,
    CFG_Z_ORIGIN      = 4'd1,
    CFG_INV_X_SPACING = 4'd2,
    CFG_INV_Z_SPACING = 4'd3,
    CFG_COLUMNS       = 4'd4,
    CFG_ROWS          = 4'd5,
    CFG_INTERP_MODE   = 4'd6,
    CFG_BOUNDS_MODE   = 4'd7
  } cfg_reg_t;

  typedef enum logic {
    INTERP_NEAREST  = 1'b0,
    INTERP_BILINEAR = 1'b1
  } interp_t;

  typedef enum logic {
    BOUNDS_CLAMP = 1'b0,
    BOUNDS_ERROR = 1'b1
  } bounds_t;

endpackage
`default_nettype wire

>>> sv/gbi_axis.sv
// One coordinate axis: offset, magnitude, scaling to Q.32 grid units and domain clamp.
`default_nettype none
module gbi_axis #(
  parameter int N_MAX = gbi_pkg::MAX_COLUMNS
) (
  input  wire logic                            clk,
  input  wire logic [31:0]                     coord,
  input  wire logic [31:0]                     origin,
  input  wire logic [31:0]                     inv,
  input  wire logic [$clog2(N_MAX+1)-1:0]      n_eff,
  output logic      [32+$clog2(N_MAX)-1:0]     pos,
  output logic                                 outside
);

  localparam int CW = $clog2(N_MAX + 1);
  localparam int PW = 32 + $clog2(N_MAX);

  logic [32:0] d_r;
  logic [32:0] absd_r;
  logic        neg_r;
  logic [64:0] mag_r;
  logic        neg2_r;
  logic [64:0] top;
  logic [PW-1:0] pos_r;
  logic          outside_r;

  always_ff @(posedge clk) begin
    d_r    <= {coord[31], coord} - {origin[31], origin};
    neg_r  <= d_r[32];
    absd_r <= d_r[32] ? (~d_r + 33'd1) : d_r;
    mag_r  <= 65'(absd_r) * 65'(inv);
    neg2_r <= neg_r;
  end

  assign top = 65'(n_eff - CW'(1)) << 32;

  always_ff @(posedge clk) begin
    if (neg2_r && (mag_r != 65'd0)) begin
      pos_r     <= '0;
      outside_r <= 1'b1;
    end else if (mag_r > top) begin
      pos_r     <= PW'(top);
      outside_r <= 1'b1;
    end else begin
      pos_r     <= PW'(mag_r);
      outside_r <= 1'b0;
    end
  end

  assign pos     = pos_r;
  assign outside = outside_r;

endmodule
`default_nettype wire

>>> sv/gbi_table.sv
// Grid property storage: two copies, each one write and two registered reads per cycle.
`default_nettype none
module gbi_table #(
  parameter int VB    = gbi_pkg::VALUE_BITS,
  parameter int DEPTH = gbi_pkg::MAX_COLUMNS * gbi_pkg::MAX_ROWS
) (
  input  wire logic                       clk,
  input  wire logic                       wr_en,
  input  wire logic [$clog2(DEPTH)-1:0]   wr_addr,
  input  wire logic [3*VB-1:0]            wr_data,
  input  wire logic [$clog2(DEPTH)-1:0]   rd_base,
  input  wire logic [$clog2(DEPTH)-1:0]   rd_step,
  input  wire logic                       near,
  output logic      [3*VB-1:0]            rd_00,
  output logic      [3*VB-1:0]            rd_10,
  output logic      [3*VB-1:0]            rd_01,
  output logic      [3*VB-1:0]            rd_11
);

  localparam int AW = $clog2(DEPTH);

  logic [3*VB-1:0] mem_a [DEPTH];
  logic [3*VB-1:0] mem_b [DEPTH];
  logic [AW-1:0]   a10, a01, a11;
  logic [3*VB-1:0] rd_00_r, rd_10_r, rd_01_r, rd_11_r;

  // Nearest lookups read the same entry on all four ports.
  assign a10 = near ? rd_base : rd_base + AW'(1);
  assign a01 = near ? rd_base : rd_base + rd_step;
  assign a11 = near ? rd_base : rd_base + rd_step + AW'(1);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_a[wr_addr] <= wr_data;
      mem_b[wr_addr] <= wr_data;
    end
    rd_00_r <= mem_a[rd_base];
    rd_10_r <= mem_a[a10];
    rd_01_r <= mem_b[a01];
    rd_11_r <= mem_b[a11];
  end

  assign rd_00 = rd_00_r;
  assign rd_10 = rd_10_r;
  assign rd_01 = rd_01_r;
  assign rd_11 = rd_11_r;

endmodule
`default_nettype wire

>>> sv/gbi_blend.sv
// Two-stage bilinear blend of one property, along x and then along z, rounded half up.
`default_nettype none
module gbi_blend #(
  parameter int VB = gbi_pkg::VALUE_BITS
) (
  input  wire logic                        clk,
  input  wire logic [VB-1:0]               t00,
  input  wire logic [VB-1:0]               t10,
  input  wire logic [VB-1:0]               t01,
  input  wire logic [VB-1:0]               t11,
  input  wire logic [gbi_pkg::WT_W-1:0]    tx,
  input  wire logic [gbi_pkg::WT_W-1:0]    tz,
  output logic      [VB-1:0]               value
);

  localparam int AB = VB + gbi_pkg::WT_W;
  localparam int SW = VB + 34;

  logic [gbi_pkg::WT_W-1:0] wx, wz;
  logic [AB-1:0] a_r, b_r;
  logic [gbi_pkg::WT_W-1:0] tz_r;
  logic [SW-1:0] s_r;
  logic [SW-1:0] rs;

  assign wx = gbi_pkg::WT_ONE - tx;
  assign wz = gbi_pkg::WT_ONE - tz_r;

  always_ff @(posedge clk) begin
    a_r  <= AB'(t00) * AB'(wx) + AB'(t10) * AB'(tx);
    b_r  <= AB'(t01) * AB'(wx) + AB'(t11) * AB'(tx);
    tz_r <= tz;
    s_r  <= SW'(a_r) * SW'(wz) + SW'(b_r) * SW'(tz_r);
  end

  assign rs    = s_r + SW'(gbi_pkg::HALF_Q32);
  assign value = rs[VB+31:32];

endmodule
`default_nettype wire

>>> sv/grid_bilinear_interpolator.sv
// Top level of the grid bilinear interpolator: configuration, control pipeline and result.
// A query's result strobe is registered after the axis, index, table read and blend stages.
// Throughput: one transaction per cycle, loads and queries mixed; busy stays low.
// The rate is held by two table copies, each read at two addresses per cycle.
// Reset clears the configuration to its defaults and empties the pipeline; table contents
// are undefined until loaded.
`default_nettype none
module grid_bilinear_interpolator #(
  parameter int MAX_COLUMNS = gbi_pkg::MAX_COLUMNS,
  parameter int MAX_ROWS    = gbi_pkg::MAX_ROWS,
  parameter int VALUE_BITS  = gbi_pkg::VALUE_BITS
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                start,
  output logic                                     busy,
  input  wire logic                                in_op,
  input  wire logic [gbi_pkg::LOAD_IDX_W-1:0]      in_load_index,
  input  wire logic [gbi_pkg::FIELD_W-1:0]         in_load_p_speed,
  input  wire logic [gbi_pkg::FIELD_W-1:0]         in_load_s_speed,
  input  wire logic [gbi_pkg::FIELD_W-1:0]         in_load_density,
  input  wire logic signed [gbi_pkg::COORD_W-1:0]  in_query_x,
  input  wire logic signed [gbi_pkg::COORD_W-1:0]  in_query_z,
  output logic                                     out_valid,
  output logic      [gbi_pkg::FIELD_W-1:0]         out_p_speed,
  output logic      [gbi_pkg::FIELD_W-1:0]         out_s_speed,
  output logic      [gbi_pkg::FIELD_W-1:0]         out_density,
  output logic                                     out_out_of_domain,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [gbi_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  wire logic [gbi_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int VB    = VALUE_BITS;
  localparam int DEPTH = MAX_COLUMNS * MAX_ROWS;
  localparam int AW    = $clog2(DEPTH);
  localparam int XW    = $clog2(MAX_COLUMNS);
  localparam int ZW    = $clog2(MAX_ROWS);
  localparam int XCW   = $clog2(MAX_COLUMNS + 1);
  localparam int ZCW   = $clog2(MAX_ROWS + 1);
  localparam int PXW   = 32 + XW;
  localparam int PZW   = 32 + ZW;
  localparam int WT    = gbi_pkg::WT_W;
  localparam int FW    = gbi_pkg::FIELD_W;

  // Configuration registers.
  logic [31:0] x_origin_r, z_origin_r, inv_x_spacing_r, inv_z_spacing_r;
  logic [gbi_pkg::COUNT_W-1:0] columns_r, rows_r;
  logic interp_mode_r, bounds_mode_r;

  logic [XCW-1:0] nc;
  logic [ZCW-1:0] nr;

  logic accept;
  logic [9:1] q_r;
  logic [6:1] ld_r;
  logic [AW-1:0]   ld_addr_r [1:6];
  logic [3*VB-1:0] ld_data_r [1:6];

  logic [PXW-1:0] pos_x;
  logic [PZW-1:0] pos_z;
  logic           out_x, out_z;

  logic           near;
  logic [XW:0]    rx;
  logic [ZW:0]    rz;
  logic [PXW:0]   rx_sum;
  logic [PZW:0]   rz_sum;
  logic [XW-1:0]  ix_n, bx, bx_c;
  logic [ZW-1:0]  iz_n, bz, bz_c;
  logic [XW+15:0] tx_diff;
  logic [ZW+15:0] tz_diff;

  logic [XW-1:0] ix5_r;
  logic [ZW-1:0] iz5_r;
  logic [WT-1:0] tx5_r, tz5_r, tx6_r, tz6_r, tx7_r, tz7_r;
  logic          near5_r, near6_r;
  logic [9:5]    err_r;
  logic [AW-1:0] idx6_r;

  logic [3*VB-1:0] rd_00, rd_10, rd_01, rd_11;
  logic [VB-1:0]   p_val, s_val, d_val;

  logic          out_valid_r, out_ood_r;
  logic [FW-1:0] out_p_r, out_s_r, out_d_r;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_origin_r      <= '0;
      z_origin_r      <= '0;
      inv_x_spacing_r <= gbi_pkg::INV_SPACING_RESET;
      inv_z_spacing_r <= gbi_pkg::INV_SPACING_RESET;
      columns_r       <= gbi_pkg::COUNT_W'(1);
      rows_r          <= gbi_pkg::COUNT_W'(1);
      interp_mode_r   <= gbi_pkg::INTERP_BILINEAR;
      bounds_mode_r   <= gbi_pkg::BOUNDS_CLAMP;
    end else if (cfg_valid && cfg_ready) begin
      unique case (gbi_pkg::cfg_reg_t'(cfg_index))
        gbi_pkg::CFG_X_ORIGIN:      x_origin_r      <= cfg_data;
        gbi_pkg::CFG_Z_ORIGIN:      z_origin_r      <= cfg_data;
        gbi_pkg::CFG_INV_X_SPACING: inv_x_spacing_r <= cfg_data;
        gbi_pkg::CFG_INV_Z_SPACING: inv_z_spacing_r <= cfg_data;
        gbi_pkg::CFG_COLUMNS:       columns_r       <= cfg_data[gbi_pkg::COUNT_W-1:0];
        gbi_pkg::CFG_ROWS:          rows_r          <= cfg_data[gbi_pkg::COUNT_W-1:0];
        gbi_pkg::CFG_INTERP_MODE:   interp_mode_r   <= cfg_data[0];
        gbi_pkg::CFG_BOUNDS_MODE:   bounds_mode_r   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // A count of zero means one; counts above the maximum saturate.
  assign nc = (columns_r == '0) ? XCW'(1) :
              (32'(columns_r) > 32'(MAX_COLUMNS)) ? XCW'(MAX_COLUMNS) : XCW'(columns_r);
  assign nr = (rows_r == '0) ? ZCW'(1) :
              (32'(rows_r) > 32'(MAX_ROWS)) ? ZCW'(MAX_ROWS) : ZCW'(rows_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r  <= '0;
      ld_r <= '0;
    end else begin
      q_r  <= {q_r[8:1], accept && (in_op == gbi_pkg::OP_QUERY)};
      ld_r <= {ld_r[5:1], accept && (in_op == gbi_pkg::OP_LOAD) &&
                          (32'(in_load_index) < 32'(DEPTH))};
    end
  end

  always_ff @(posedge clk) begin
    ld_addr_r[1] <= AW'(in_load_index);
    ld_data_r[1] <= {VB'(in_load_p_speed), VB'(in_load_s_speed), VB'(in_load_density)};
    for (int i = 2; i <= 6; i++) begin
      ld_addr_r[i] <= ld_addr_r[i-1];
      ld_data_r[i] <= ld_data_r[i-1];
    end
  end

  gbi_axis #(.N_MAX(MAX_COLUMNS)) u_axis_x (
    .clk     (clk),
    .coord   (in_query_x),
    .origin  (x_origin_r),
    .inv     (inv_x_spacing_r),
    .n_eff   (nc),
    .pos     (pos_x),
    .outside (out_x)
  );

  gbi_axis #(.N_MAX(MAX_ROWS)) u_axis_z (
    .clk     (clk),
    .coord   (in_query_z),
    .origin  (z_origin_r),
    .inv     (inv_z_spacing_r),
    .n_eff   (nr),
    .pos     (pos_z),
    .outside (out_z)
  );

  assign near = (interp_mode_r == gbi_pkg::INTERP_NEAREST) ||
                (nc == XCW'(1)) || (nr == ZCW'(1));

  // Nearest index: round half up, then clamp to the last entry.
  assign rx_sum = (PXW+1)'(pos_x) + (PXW+1)'(gbi_pkg::HALF_Q32);
  assign rz_sum = (PZW+1)'(pos_z) + (PZW+1)'(gbi_pkg::HALF_Q32);
  assign rx     = rx_sum[PXW:32];
  assign rz     = rz_sum[PZW:32];
  assign ix_n   = (32'(rx) > 32'(nc) - 32'd1) ? XW'(nc - XCW'(1)) : XW'(rx);
  assign iz_n   = (32'(rz) > 32'(nr) - 32'd1) ? ZW'(nr - ZCW'(1)) : ZW'(rz);

  // Bilinear cell: floor, clamped to the second-last index.
  assign bx      = pos_x[PXW-1:32];
  assign bz      = pos_z[PZW-1:32];
  assign bx_c    = (32'(bx) > 32'(nc) - 32'd2) ? XW'(nc - XCW'(2)) : bx;
  assign bz_c    = (32'(bz) > 32'(nr) - 32'd2) ? ZW'(nr - ZCW'(2)) : bz;
  assign tx_diff = pos_x[PXW-1:16] - {bx_c, 16'h0000};
  assign tz_diff = pos_z[PZW-1:16] - {bz_c, 16'h0000};

  always_ff @(posedge clk) begin
    near5_r <= near;
    ix5_r   <= near ? ix_n : bx_c;
    iz5_r   <= near ? iz_n : bz_c;
    tx5_r   <= near ? '0 : tx_diff[WT-1:0];
    tz5_r   <= near ? '0 : tz_diff[WT-1:0];
    err_r[5] <= (bounds_mode_r == gbi_pkg::BOUNDS_ERROR) && (out_x || out_z);
    err_r[9:6] <= err_r[8:5];

    idx6_r  <= AW'(iz5_r) * AW'(nc) + AW'(ix5_r);
    near6_r <= near5_r;
    tx6_r   <= tx5_r;
    tz6_r   <= tz5_r;
    tx7_r   <= tx6_r;
    tz7_r   <= tz6_r;
  end

  // Loads write in the same stage that queries read, so a query sees every earlier load.
  gbi_table #(.VB(VB), .DEPTH(DEPTH)) u_table (
    .clk     (clk),
    .wr_en   (ld_r[6]),
    .wr_addr (ld_addr_r[6]),
    .wr_data (ld_data_r[6]),
    .rd_base (idx6_r),
    .rd_step (AW'(nc)),
    .near    (near6_r),
    .rd_00   (rd_00),
    .rd_10   (rd_10),
    .rd_01   (rd_01),
    .rd_11   (rd_11)
  );

  gbi_blend #(.VB(VB)) u_blend_p (
    .clk (clk),
    .t00 (rd_00[3*VB-1:2*VB]), .t10 (rd_10[3*VB-1:2*VB]),
    .t01 (rd_01[3*VB-1:2*VB]), .t11 (rd_11[3*VB-1:2*VB]),
    .tx  (tx7_r), .tz (tz7_r), .value (p_val)
  );

  gbi_blend #(.VB(VB)) u_blend_s (
    .clk (clk),
    .t00 (rd_00[2*VB-1:VB]), .t10 (rd_10[2*VB-1:VB]),
    .t01 (rd_01[2*VB-1:VB]), .t11 (rd_11[2*VB-1:VB]),
    .tx  (tx7_r), .tz (tz7_r), .value (s_val)
  );

  gbi_blend #(.VB(VB)) u_blend_d (
    .clk (clk),
    .t00 (rd_00[VB-1:0]), .t10 (rd_10[VB-1:0]),
    .t01 (rd_01[VB-1:0]), .t11 (rd_11[VB-1:0]),
    .tx  (tx7_r), .tz (tz7_r), .value (d_val)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      out_ood_r   <= 1'b0;
    end else begin
      out_valid_r <= q_r[9];
      out_ood_r   <= q_r[9] && err_r[9];
    end
    out_p_r <= err_r[9] ? '0 : FW'(p_val);
    out_s_r <= err_r[9] ? '0 : FW'(s_val);
    out_d_r <= err_r[9] ? '0 : FW'(d_val);
  end

  assign out_valid         = out_valid_r;
  assign out_out_of_domain = out_ood_r;
  assign out_p_speed       = out_p_r;
  assign out_s_speed       = out_s_r;
  assign out_density       = out_d_r;

  a_query_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_op == gbi_pkg::OP_QUERY) |-> ##10 out_valid)
    else $error("query transaction produced no result");

  a_load_gives_none: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_op == gbi_pkg::OP_LOAD) |-> ##10 !out_valid)
    else $error("load transaction produced a result");

  a_ood_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_out_of_domain) |->
      (out_p_speed == '0 && out_s_speed == '0 && out_density == '0 &&
       bounds_mode_r == gbi_pkg::BOUNDS_ERROR))
    else $error("out-of-domain result with nonzero values or in clamp mode");

endmodule
`default_nettype wire

>>> tb/sv/gbi_checker.sv
// Checker for the grid bilinear interpolator: watches the channels, predicts and compares results.
`timescale 1ns / 100ps
`default_nettype none
module gbi_checker
  import gbi_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     start,
  input  wire logic                     busy,
  input  wire logic                     in_op,
  input  wire logic [LOAD_IDX_W-1:0]    in_load_index,
  input  wire logic [FIELD_W-1:0]       in_load_p_speed,
  input  wire logic [FIELD_W-1:0]       in_load_s_speed,
  input  wire logic [FIELD_W-1:0]       in_load_density,
  input  wire logic [COORD_W-1:0]       in_query_x,
  input  wire logic [COORD_W-1:0]       in_query_z,
  input  wire logic                     out_valid,
  input  wire logic [FIELD_W-1:0]       out_p_speed,
  input  wire logic [FIELD_W-1:0]       out_s_speed,
  input  wire logic [FIELD_W-1:0]       out_density,
  input  wire logic                     out_out_of_domain,
  input  wire logic                     cfg_valid,
  input  wire logic                     cfg_ready,
  input  wire logic [CFG_INDEX_W-1:0]   cfg_index,
  input  wire logic [CFG_DATA_W-1:0]    cfg_data,
  output int                            error_count,
  output int                            pending_count
);

  typedef struct packed {
    logic [FIELD_W-1:0] p_speed;
    logic [FIELD_W-1:0] s_speed;
    logic [FIELD_W-1:0] density;
    logic               out_of_domain;
  } sample_t;

  localparam int DEPTH = MAX_COLUMNS * MAX_ROWS;

  logic signed [31:0] x_org, z_org;
  logic [31:0]        inv_x, inv_z;
  logic [6:0]         n_cols, n_rows;
  interp_t            interp;
  bounds_t            bounds;
  logic [23:0]        p_tab [DEPTH];
  logic [23:0]        s_tab [DEPTH];
  logic [23:0]        d_tab [DEPTH];
  sample_t            expected_samples[$];

  function automatic int clamp_count(logic [6:0] n, int max_n);
    if (n == 0) return 1;
    return (n > max_n) ? max_n : int'(n);
  endfunction

  // Position in Q.32 grid units, clamped to the domain.
  function automatic logic [63:0] to_grid(logic signed [31:0] coord, logic signed [31:0] org,
                                         logic [31:0] inv, int n, inout bit outside);
    logic signed [33:0] d;
    logic [32:0]        mag_d;
    logic [63:0]        mag, top;
    d = 34'(coord) - 34'(org);
    mag_d = d[33] ? 33'(-d) : 33'(d);
    mag = 64'(mag_d) * 64'(inv);
    top = 64'(n - 1) << 32;
    if (d[33] && mag != 0) begin
      outside = 1;
      return 64'd0;
    end
    if (mag > top) begin
      outside = 1;
      return top;
    end
    return mag;
  endfunction

  function automatic logic [23:0] mix4(logic [23:0] v00, logic [23:0] v10, logic [23:0] v01,
                                       logic [23:0] v11, logic [63:0] tx, logic [63:0] tz);
    logic [63:0] a, b, s;
    a = 64'(v00) * (64'd65536 - tx) + 64'(v10) * tx;
    b = 64'(v01) * (64'd65536 - tx) + 64'(v11) * tx;
    s = a * (64'd65536 - tz) + b * tz;
    return 24'((s + 64'h8000_0000) >> 32);
  endfunction

  function automatic sample_t interpolate(logic signed [31:0] qx, logic signed [31:0] qz);
    sample_t     r;
    bit          outside;
    int          nc, nr;
    logic [63:0] u, w, ix, iz, tx, tz;
    int          i00;
    outside = 0;
    nc = clamp_count(n_cols, MAX_COLUMNS);
    nr = clamp_count(n_rows, MAX_ROWS);
    u = to_grid(qx, x_org, inv_x, nc, outside);
    w = to_grid(qz, z_org, inv_z, nr, outside);
    r = '0;
    if (bounds == BOUNDS_ERROR && outside) begin
      r.out_of_domain = 1'b1;
      return r;
    end
    if (interp == INTERP_NEAREST || nc == 1 || nr == 1) begin
      ix = (u + 64'h8000_0000) >> 32;
      iz = (w + 64'h8000_0000) >> 32;
      if (ix > nc - 1) ix = nc - 1;
      if (iz > nr - 1) iz = nr - 1;
      i00 = int'(iz) * nc + int'(ix);
      r.p_speed = p_tab[i00];
      r.s_speed = s_tab[i00];
      r.density = d_tab[i00];
    end else begin
      ix = u >> 32;
      iz = w >> 32;
      if (ix > nc - 2) ix = nc - 2;
      if (iz > nr - 2) iz = nr - 2;
      tx = (u >> 16) - (ix << 16);
      tz = (w >> 16) - (iz << 16);
      i00 = int'(iz) * nc + int'(ix);
      r.p_speed = mix4(p_tab[i00], p_tab[i00+1], p_tab[i00+nc], p_tab[i00+nc+1], tx, tz);
      r.s_speed = mix4(s_tab[i00], s_tab[i00+1], s_tab[i00+nc], s_tab[i00+nc+1], tx, tz);
      r.density = mix4(d_tab[i00], d_tab[i00+1], d_tab[i00+nc], d_tab[i00+nc+1], tx, tz);
    end
    return r;
  endfunction

  assign pending_count = expected_samples.size();

  always @(posedge clk) begin
    sample_t want, got;
    if (!rst_n) begin
      x_org  <= '0;
      z_org  <= '0;
      inv_x  <= INV_SPACING_RESET;
      inv_z  <= INV_SPACING_RESET;
      n_cols <= 7'd1;
      n_rows <= 7'd1;
      interp <= INTERP_BILINEAR;
      bounds <= BOUNDS_CLAMP;
      error_count <= 0;
      expected_samples.delete();
    end else begin
      if (out_valid) begin
        got = '{out_p_speed, out_s_speed, out_density, out_out_of_domain};
        if (expected_samples.size() == 0) begin
          $display("%0t: unexpected result, actual %h", $time, got);
          error_count <= error_count + 1;
        end else begin
          want = expected_samples.pop_front();
          if (got !== want) begin
            $display("%0t: result mismatch, expected p=%h s=%h d=%h ood=%b, actual p=%h s=%h d=%h ood=%b",
                     $time, want.p_speed, want.s_speed, want.density, want.out_of_domain,
                     got.p_speed, got.s_speed, got.density, got.out_of_domain);
            error_count <= error_count + 1;
          end
        end
      end
      if (start && !busy) begin
        if (op_t'(in_op) == OP_LOAD) begin
          p_tab[in_load_index] = in_load_p_speed;
          s_tab[in_load_index] = in_load_s_speed;
          d_tab[in_load_index] = in_load_density;
        end else begin
          expected_samples.push_back(interpolate(in_query_x, in_query_z));
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          CFG_X_ORIGIN:      x_org  <= cfg_data;
          CFG_Z_ORIGIN:      z_org  <= cfg_data;
          CFG_INV_X_SPACING: inv_x  <= cfg_data;
          CFG_INV_Z_SPACING: inv_z  <= cfg_data;
          CFG_COLUMNS:       n_cols <= cfg_data[6:0];
          CFG_ROWS:          n_rows <= cfg_data[6:0];
          CFG_INTERP_MODE:   interp <= interp_t'(cfg_data[0]);
          CFG_BOUNDS_MODE:   bounds <= bounds_t'(cfg_data[0]);
          default: ;
        endcase
      end
    end
  end

endmodule
`default_nettype wire

>>> tb/sv/tb_top.sv
// Top of the grid bilinear interpolator testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
  import gbi_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int GRID_BUDGET = 640;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   start = 1'b0;
  logic                   busy;
  logic                   in_op = 1'b0;
  logic [LOAD_IDX_W-1:0]  in_load_index = '0;
  logic [FIELD_W-1:0]     in_load_p_speed = '0;
  logic [FIELD_W-1:0]     in_load_s_speed = '0;
  logic [FIELD_W-1:0]     in_load_density = '0;
  logic [COORD_W-1:0]     in_query_x = '0;
  logic [COORD_W-1:0]     in_query_z = '0;
  logic                   out_valid;
  logic [FIELD_W-1:0]     out_p_speed, out_s_speed, out_density;
  logic                   out_out_of_domain;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  int                     error_count, pending_count;
  int                     idle_cycles;
  int                     idle_pct;
  int                     grid_cols, grid_rows;
  int                     loaded_count = 0;
  int                     phase_cols, phase_rows;

  always #10 clk = ~clk;

  grid_bilinear_interpolator u_dut (.*);

  gbi_checker u_checker (.*);

  // Watchdog on cycles with no accepted transaction of any kind and no result.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  function automatic int eff_count(int n, int max_n);
    return (n == 0) ? 1 : ((n > max_n) ? max_n : n);
  endfunction

  task automatic write_reg(cfg_reg_t idx, logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    while (pending_count != 0) @(posedge clk);
    repeat (14) @(posedge clk);
  endtask

  task automatic issue(op_t op, int idx, logic [31:0] qx, logic [31:0] qz);
    while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start           <= 1'b1;
    in_op           <= op;
    in_load_index   <= LOAD_IDX_W'(idx);
    in_load_p_speed <= FIELD_W'($urandom);
    in_load_s_speed <= FIELD_W'($urandom);
    in_load_density <= FIELD_W'($urandom);
    in_query_x      <= qx;
    in_query_z      <= qz;
    do @(posedge clk); while (busy);
  endtask

  task automatic stop_issue();
    start <= 1'b0;
    @(posedge clk);
  endtask

  // Sets up a grid and loads every entry in use that was never loaded, so no query
  // reads an unwritten entry. Table contents carry over from one grid to the next.
  task automatic set_grid(int nc, int nr, logic [31:0] xo, logic [31:0] zo,
                          logic [31:0] ix, logic [31:0] iz, interp_t im, bounds_t bm);
    drain();
    write_reg(CFG_X_ORIGIN, xo);
    write_reg(CFG_Z_ORIGIN, zo);
    write_reg(CFG_INV_X_SPACING, ix);
    write_reg(CFG_INV_Z_SPACING, iz);
    write_reg(CFG_COLUMNS, nc);
    write_reg(CFG_ROWS, nr);
    write_reg(CFG_INTERP_MODE, im);
    write_reg(CFG_BOUNDS_MODE, bm);
    grid_cols = eff_count(nc, MAX_COLUMNS);
    grid_rows = eff_count(nr, MAX_ROWS);
    for (int i = loaded_count; i < grid_cols * grid_rows; i++) issue(OP_LOAD, i, $urandom, $urandom);
    if (grid_cols * grid_rows > loaded_count) loaded_count = grid_cols * grid_rows;
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(3))
      0: return $urandom;
      1: return $urandom_range(0, 64 * 256) - 256;
      2: return {$urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF};
      default: return $urandom_range(0, 20 * 256);
    endcase
  endfunction

  initial begin
    idle_pct = 18;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset grid of one entry, then extremes of coordinates, load indices and configuration.
    issue(OP_LOAD, 0, 0, 0);
    issue(OP_QUERY, 0, 32'h8000_0000, 32'h7FFF_FFFF);
    issue(OP_LOAD, 4095, 0, 0);
    issue(OP_LOAD, 4095 - 1, 0, 0);
    stop_issue();
    set_grid(64, 2, 0, 0, 32'h0100_0000, 32'h0100_0000, INTERP_BILINEAR, BOUNDS_ERROR);
    issue(OP_QUERY, 0, 32'h8000_0000, 0);
    issue(OP_QUERY, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    issue(OP_QUERY, 0, 63 * 256, 256);
    issue(OP_QUERY, 0, 63 * 256 + 1, 0);
    issue(OP_QUERY, 0, 32'hFFFF_FFFF, 0);
    issue(OP_QUERY, 0, 128, 192);
    issue(OP_LOAD, 0, 0, 0);
    issue(OP_QUERY, 0, 0, 0);
    stop_issue();
    set_grid(0, 100, 32'h8000_0000, 32'h7FFF_FFFF, 0, 32'hFFFF_FFFF, INTERP_NEAREST,
             BOUNDS_CLAMP);
    issue(OP_QUERY, 0, 32'h7FFF_FFFF, 32'h8000_0000);
    issue(OP_QUERY, 0, 32'h8000_0000, 32'h7FFF_FFFF);
    stop_issue();

    // Random phases over several grid settings.
    for (int ph = 0; ph < 24; ph++) begin
      idle_pct = (ph % 5 == 2) ? 0 : 18;
      phase_cols = $urandom_range(0, 127) % 66;
      phase_rows = $urandom_range(0, 127) % 66;
      // Large grids keep few rows so the number of loads stays small.
      if (eff_count(phase_cols, MAX_COLUMNS) * eff_count(phase_rows, MAX_ROWS) > GRID_BUDGET)
        phase_rows = $urandom_range(1, GRID_BUDGET / eff_count(phase_cols, MAX_COLUMNS));
      set_grid(phase_cols, phase_rows,
               $urandom_range(1) ? $urandom : $urandom_range(0, 512) - 256,
               $urandom_range(1) ? $urandom : $urandom_range(0, 512) - 256,
               $urandom_range(3) == 0 ? $urandom : $urandom_range(1, 4) << 24,
               $urandom_range(3) == 0 ? $urandom : $urandom_range(1, 4) << 24,
               interp_t'($urandom_range(1)), bounds_t'($urandom_range(1)));
      for (int k = 0; k < 42; k++) begin
        if ($urandom_range(9) == 0)
          issue(OP_LOAD, $urandom_range(grid_cols * grid_rows - 1), 0, 0);
        else
          issue(OP_QUERY, 0, rand_coord(), rand_coord());
      end
      stop_issue();
      // After phase 3, hold off until every pending result has come back.
      if (ph == 3) while (pending_count != 0) @(posedge clk);
    end

    drain();
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
`default_nettype wire
